/* hw/rtl/shp_pkg.sv */
`default_nettype none

package shp_pkg;

	// Configuration port
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] RegEta        = 3'd0;
	localparam logic [CfgIdxW-1:0] RegBetaStart  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegBetaFinal  = 3'd2;
	localparam logic [CfgIdxW-1:0] RegBetaFactor = 3'd3;
	localparam logic [CfgIdxW-1:0] RegBetaPeriod = 3'd4;

	localparam logic [15:0] EtaRst        = 16'd16384;
	localparam logic [15:0] BetaStartRst  = 16'd256;
	localparam logic [15:0] BetaFinalRst  = 16'd16384;
	localparam logic [11:0] BetaFactorRst = 12'd512;
	localparam logic [15:0] BetaPeriodRst = 16'd10;

	// Fixed-point constants
	localparam logic [30:0] One30    = 31'h4000_0000;
	localparam logic [27:0] UClamp   = 28'h800_0000;
	localparam logic [63:0] Half30   = 64'h0000_0000_2000_0000;
	localparam logic [63:0] Half24   = 64'h0000_0000_0080_0000;
	localparam logic [31:0] Half15   = 32'h0000_4000;
	localparam logic [39:0] NegLimit = 40'h00_8000_0000;
	localparam logic [39:0] PosLimit = 40'h00_7FFF_FFFF;

	// Series and squaring loop bounds
	localparam logic [2:0] TaylorFirst = 3'd2;
	localparam logic [2:0] TaylorLast  = 3'd7;
	localparam logic [2:0] SquareLast  = 3'd4;

	// Restoring divider: one quotient bit per cycle
	localparam int unsigned DivSteps = 31;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_U,
		ST_INIT_W,
		ST_MUL_TW,
		ST_MUL_RC,
		ST_TERM,
		ST_MUL_SQ,
		ST_ROUND_SQ,
		ST_DIV_P,
		ST_WAIT_P,
		ST_SIGMOID,
		ST_MUL_Q,
		ST_MUL_D,
		ST_MUL_G,
		ST_OUT_PROJ,
		ST_MUL_BETA,
		ST_DIV_MOD,
		ST_WAIT_MOD,
		ST_OUT_UPD
	} shp_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_U,
		OP_INIT_W,
		OP_MUL_TW,
		OP_MUL_RC,
		OP_TERM,
		OP_MUL_SQ,
		OP_ROUND_SQ,
		OP_DIV_P,
		OP_SIGMOID,
		OP_MUL_Q,
		OP_MUL_D,
		OP_MUL_G,
		OP_OUT_PROJ,
		OP_MUL_BETA,
		OP_DIV_MOD,
		OP_OUT_UPD
	} shp_op_t;

	typedef struct packed {
		shp_op_t    op;
		logic [2:0] k;
	} shp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} shp_stat_t;

	// floor(2^32 / k); the quotient it gives is at most one short
	function automatic logic [31:0] recip(input logic [2:0] k);
		logic [31:0] m;
		unique case (k)
			3'd2:    m = 32'h8000_0000;
			3'd3:    m = 32'h5555_5555;
			3'd4:    m = 32'h4000_0000;
			3'd5:    m = 32'h3333_3333;
			3'd6:    m = 32'h2AAA_AAAA;
			3'd7:    m = 32'h2492_4924;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/shp_div.sv */
`default_nettype none

module shp_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [31:0]                    rem_init,
	input  wire logic [shp_pkg::DivSteps-1:0]   dvd,
	input  wire logic [31:0]                    dsr,
	output logic      [shp_pkg::DivSteps-1:0]   quo,
	output logic      [31:0]                    rem,
	output logic                                busy
);

	logic                             busy_q;
	logic [shp_pkg::DivCntW-1:0]      cnt_q;
	logic [31:0]                      rem_q;
	logic [31:0]                      dsr_q;
	logic [shp_pkg::DivSteps-1:0]     dvd_q;
	logic [shp_pkg::DivSteps-1:0]     quo_q;
	logic [31:0]                      trial;
	logic                             ge;

	// Remainder stays below the divisor, so the shifted value fits 32 bits
	assign trial = {rem_q[30:0], dvd_q[shp_pkg::DivSteps-1]};
	assign ge    = trial >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= shp_pkg::DivCntW'(shp_pkg::DivSteps - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - shp_pkg::DivCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dvd;
			dsr_q <= dsr;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - dsr_q : trial;
			dvd_q <= {dvd_q[shp_pkg::DivSteps-2:0], 1'b0};
			quo_q <= {quo_q[shp_pkg::DivSteps-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign busy = busy_q;

endmodule

`default_nettype wire

/* hw/rtl/shp_ctrl.sv */
`default_nettype none

module shp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              func,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output shp_pkg::shp_cmd_t      cmd,
	input  wire shp_pkg::shp_stat_t stat
);

	shp_pkg::shp_state_t state_q, state_d;
	logic [2:0]          k_q, k_d;
	logic [2:0]          sq_q, sq_d;
	logic                out_valid_q, out_valid_d;
	logic                out_free;
	logic                out_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shp_pkg::ST_IDLE;
			k_q         <= '0;
			sq_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			sq_q        <= sq_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		sq_d     = sq_q;
		cmd.op   = shp_pkg::OP_NONE;
		cmd.k    = k_q;
		in_ready = 1'b0;
		out_set  = 1'b0;
		unique case (state_q)
			shp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = shp_pkg::OP_LOAD;
					state_d = func ? shp_pkg::ST_MUL_BETA : shp_pkg::ST_MUL_U;
				end
			end
			shp_pkg::ST_MUL_U: begin
				cmd.op  = shp_pkg::OP_MUL_U;
				state_d = shp_pkg::ST_INIT_W;
			end
			shp_pkg::ST_INIT_W: begin
				cmd.op  = shp_pkg::OP_INIT_W;
				k_d     = shp_pkg::TaylorFirst;
				state_d = shp_pkg::ST_MUL_TW;
			end
			shp_pkg::ST_MUL_TW: begin
				cmd.op  = shp_pkg::OP_MUL_TW;
				state_d = shp_pkg::ST_MUL_RC;
			end
			shp_pkg::ST_MUL_RC: begin
				cmd.op  = shp_pkg::OP_MUL_RC;
				state_d = shp_pkg::ST_TERM;
			end
			shp_pkg::ST_TERM: begin
				cmd.op = shp_pkg::OP_TERM;
				if (k_q == shp_pkg::TaylorLast) begin
					sq_d    = '0;
					state_d = shp_pkg::ST_MUL_SQ;
				end else begin
					k_d     = k_q + 3'd1;
					state_d = shp_pkg::ST_MUL_TW;
				end
			end
			shp_pkg::ST_MUL_SQ: begin
				cmd.op  = shp_pkg::OP_MUL_SQ;
				state_d = shp_pkg::ST_ROUND_SQ;
			end
			shp_pkg::ST_ROUND_SQ: begin
				cmd.op = shp_pkg::OP_ROUND_SQ;
				if (sq_q == shp_pkg::SquareLast) begin
					state_d = shp_pkg::ST_DIV_P;
				end else begin
					sq_d    = sq_q + 3'd1;
					state_d = shp_pkg::ST_MUL_SQ;
				end
			end
			shp_pkg::ST_DIV_P: begin
				cmd.op  = shp_pkg::OP_DIV_P;
				state_d = shp_pkg::ST_WAIT_P;
			end
			shp_pkg::ST_WAIT_P: begin
				if (!stat.div_busy) begin
					state_d = shp_pkg::ST_SIGMOID;
				end
			end
			shp_pkg::ST_SIGMOID: begin
				cmd.op  = shp_pkg::OP_SIGMOID;
				state_d = shp_pkg::ST_MUL_Q;
			end
			shp_pkg::ST_MUL_Q: begin
				cmd.op  = shp_pkg::OP_MUL_Q;
				state_d = shp_pkg::ST_MUL_D;
			end
			shp_pkg::ST_MUL_D: begin
				cmd.op  = shp_pkg::OP_MUL_D;
				state_d = shp_pkg::ST_MUL_G;
			end
			shp_pkg::ST_MUL_G: begin
				cmd.op  = shp_pkg::OP_MUL_G;
				state_d = shp_pkg::ST_OUT_PROJ;
			end
			shp_pkg::ST_OUT_PROJ: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.op  = shp_pkg::OP_OUT_PROJ;
					out_set = 1'b1;
					state_d = shp_pkg::ST_IDLE;
				end
			end
			shp_pkg::ST_MUL_BETA: begin
				cmd.op  = shp_pkg::OP_MUL_BETA;
				state_d = shp_pkg::ST_DIV_MOD;
			end
			shp_pkg::ST_DIV_MOD: begin
				cmd.op  = shp_pkg::OP_DIV_MOD;
				state_d = shp_pkg::ST_WAIT_MOD;
			end
			shp_pkg::ST_WAIT_MOD: begin
				if (!stat.div_busy) begin
					state_d = shp_pkg::ST_OUT_UPD;
				end
			end
			shp_pkg::ST_OUT_UPD: begin
				if (out_free) begin
					cmd.op  = shp_pkg::OP_OUT_UPD;
					out_set = 1'b1;
					state_d = shp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shp_pkg::ST_IDLE;
			end
		endcase
		out_valid_d = out_set ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/shp_dp.sv */
`default_nettype none

module shp_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [shp_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [shp_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic [15:0]                   iteration,
	input  wire logic [15:0]                   density_in,
	input  wire logic signed [31:0]            grad_in,
	input  wire shp_pkg::shp_cmd_t             cmd,
	output shp_pkg::shp_stat_t                 stat,
	output logic [15:0]                        density_out,
	output logic signed [31:0]                 grad_out,
	output logic [15:0]                        beta_now
);

	// Configuration and continuation state
	logic [15:0] eta_q;
	logic [15:0] beta_final_q;
	logic [11:0] beta_factor_q;
	logic [15:0] beta_period_q;
	logic [15:0] beta_cur_q;

	// Item and working registers
	logic [15:0] iter_q;
	logic [15:0] ad_q;
	logic        pos_q;
	logic        gneg_q;
	logic [31:0] mag_q;
	logic [63:0] prod_q;
	logic [29:0] w_q;
	logic [29:0] term_q;
	logic [29:0] tq_q;
	logic [30:0] r_q;
	logic [30:0] s_q;

	// Shared multiplier
	logic        mul_en;
	logic [31:0] mul_a;
	logic [31:0] mul_b;

	// Divider hookup
	logic                           div_start;
	logic [31:0]                    div_rem_init;
	logic [shp_pkg::DivSteps-1:0]   div_dvd;
	logic [31:0]                    div_dsr;
	logic [shp_pkg::DivSteps-1:0]   div_quo;
	logic [31:0]                    div_rem;
	logic                           div_busy;

	// Combinational helpers
	logic        pos_in;
	logic [15:0] ad_in;
	logic [31:0] graw;
	logic [31:0] mag_in;
	logic [32:0] u_full;
	logic [27:0] u_cl;
	logic [29:0] q0;
	logic [32:0] q0k;
	logic [32:0] rr;
	logic [29:0] q_fix;
	logic [63:0] sq_sum;
	logic [31:0] den;
	logic [30:0] p_val;
	logic [63:0] g_sum;
	logic [39:0] g_res;
	logic [31:0] g_sat;
	logic [31:0] g_val;
	logic [31:0] dens_sum;
	logic [19:0] cand;
	logic [15:0] cand_min;
	logic        step_ok;
	logic [15:0] beta_next;

	assign pos_in = density_in >= eta_q;
	assign ad_in  = pos_in ? density_in - eta_q : eta_q - density_in;
	assign graw   = grad_in;
	assign mag_in = graw[31] ? (~graw + 32'd1) : graw;

	// u = 2*beta*|x-eta| in Q.23, clamped to 16.0
	assign u_full = {prod_q[31:0], 1'b0};
	assign u_cl   = (u_full > 33'(shp_pkg::UClamp)) ? shp_pkg::UClamp : u_full[27:0];

	// Reciprocal quotient, then one fix-up step
	assign q0    = prod_q[61:32];
	assign q0k   = 33'(q0) * 33'(cmd.k);
	assign rr    = 33'(tq_q) - q0k;
	assign q_fix = q0 + 30'(rr >= 33'(cmd.k));

	assign sq_sum = prod_q + shp_pkg::Half30;
	assign den    = 32'(r_q) + 32'(shp_pkg::One30);
	assign p_val  = (div_quo > shp_pkg::One30) ? shp_pkg::One30 : div_quo;

	assign g_sum = prod_q + shp_pkg::Half24;
	assign g_res = g_sum[63:24];
	always_comb begin
		if (gneg_q) begin
			g_sat = (g_res > shp_pkg::NegLimit) ? shp_pkg::NegLimit[31:0] : g_res[31:0];
			g_val = ~g_sat + 32'd1;
		end else begin
			g_sat = (g_res > shp_pkg::PosLimit) ? shp_pkg::PosLimit[31:0] : g_res[31:0];
			g_val = g_sat;
		end
	end
	assign dens_sum = 32'(s_q) + shp_pkg::Half15;

	// Continuation step
	assign cand      = prod_q[27:8];
	assign cand_min  = (cand < 20'(beta_final_q)) ? cand[15:0] : beta_final_q;
	assign step_ok   = (iter_q != '0) && (beta_period_q != '0) && (div_rem == '0)
	                   && (beta_cur_q < beta_final_q);
	assign beta_next = step_ok ? cand_min : beta_cur_q;

	// Operand select for the shared multiplier and the divider
	always_comb begin
		mul_en       = 1'b1;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_rem_init = '0;
		div_dvd      = '0;
		div_dsr      = '0;
		unique case (cmd.op)
			shp_pkg::OP_MUL_U: begin
				mul_a = 32'(beta_cur_q);
				mul_b = 32'(ad_q);
			end
			shp_pkg::OP_MUL_TW: begin
				mul_a = 32'(term_q);
				mul_b = 32'(w_q);
			end
			shp_pkg::OP_MUL_RC: begin
				mul_a = 32'(prod_q[59:30]);
				mul_b = shp_pkg::recip(cmd.k);
			end
			shp_pkg::OP_MUL_SQ: begin
				mul_a = 32'(r_q);
				mul_b = 32'(r_q);
			end
			shp_pkg::OP_MUL_Q: begin
				mul_a = 32'(s_q);
				mul_b = 32'(shp_pkg::One30 - s_q);
			end
			shp_pkg::OP_MUL_D: begin
				mul_a = 32'(prod_q[58:30]);
				mul_b = 32'(beta_cur_q);
			end
			shp_pkg::OP_MUL_G: begin
				mul_a = mag_q;
				mul_b = 32'(prod_q[43:13]);
			end
			shp_pkg::OP_MUL_BETA: begin
				mul_a = 32'(beta_cur_q);
				mul_b = 32'(beta_factor_q);
			end
			shp_pkg::OP_DIV_P: begin
				// round(2^60 / den): top of the dividend is 2^29, low bits den/2
				mul_en       = 1'b0;
				div_start    = 1'b1;
				div_rem_init = 32'h2000_0000;
				div_dvd      = den[31:1];
				div_dsr      = den;
			end
			shp_pkg::OP_DIV_MOD: begin
				mul_en       = 1'b0;
				div_start    = 1'b1;
				div_dvd      = shp_pkg::DivSteps'(iter_q);
				div_dsr      = 32'(beta_period_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	shp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.dvd      (div_dvd),
		.dsr      (div_dsr),
		.quo      (div_quo),
		.rem      (div_rem),
		.busy     (div_busy)
	);

	assign stat.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q         <= shp_pkg::EtaRst;
			beta_final_q  <= shp_pkg::BetaFinalRst;
			beta_factor_q <= shp_pkg::BetaFactorRst;
			beta_period_q <= shp_pkg::BetaPeriodRst;
			beta_cur_q    <= shp_pkg::BetaStartRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				shp_pkg::RegEta:        eta_q         <= cfg_data;
				shp_pkg::RegBetaStart:  beta_cur_q    <= cfg_data;
				shp_pkg::RegBetaFinal:  beta_final_q  <= cfg_data;
				shp_pkg::RegBetaFactor: beta_factor_q <= cfg_data[11:0];
				shp_pkg::RegBetaPeriod: beta_period_q <= cfg_data;
				default: begin
				end
			endcase
		end else if (cmd.op == shp_pkg::OP_OUT_UPD) begin
			beta_cur_q <= beta_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= 64'(mul_a) * 64'(mul_b);
		end
		unique case (cmd.op)
			shp_pkg::OP_LOAD: begin
				iter_q <= iteration;
				pos_q  <= pos_in;
				ad_q   <= ad_in;
				gneg_q <= graw[31];
				mag_q  <= mag_in;
			end
			shp_pkg::OP_INIT_W: begin
				// first series term is w itself
				w_q    <= {u_cl, 2'b00};
				term_q <= {u_cl, 2'b00};
				r_q    <= shp_pkg::One30 - 31'({u_cl, 2'b00});
			end
			shp_pkg::OP_MUL_RC: begin
				tq_q <= prod_q[59:30];
			end
			shp_pkg::OP_TERM: begin
				term_q <= q_fix;
				r_q    <= cmd.k[0] ? r_q - 31'(q_fix) : r_q + 31'(q_fix);
			end
			shp_pkg::OP_ROUND_SQ: begin
				r_q <= sq_sum[60:30];
			end
			shp_pkg::OP_SIGMOID: begin
				s_q <= pos_q ? p_val : shp_pkg::One30 - p_val;
			end
			shp_pkg::OP_OUT_PROJ: begin
				density_out <= dens_sum[30:15];
				grad_out    <= $signed(g_val);
				beta_now    <= beta_cur_q;
			end
			shp_pkg::OP_OUT_UPD: begin
				density_out <= '0;
				grad_out    <= '0;
				beta_now    <= beta_next;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/smooth_heaviside_projection_top.sv */
`default_nettype none

// Logistic Heaviside projection with beta continuation. A project word (func 0)
// returns s = 1/(1+exp(-2*beta*(x-eta))) in Q1.15 and the Q16.16 gradient scaled
// by s*(1-s)*2*beta, saturated to 32 bits; an update word (func 1) multiplies
// beta by beta_factor, capped at beta_final, when beta is below beta_final and
// the iteration is a nonzero multiple of beta_period, and returns zeros with
// the new beta. Every word yields one result word. One word is in work at a
// time. The restoring divider serves the reciprocal in the sigmoid and the
// period check on update; the single shared 32x32 multiplier serves the series,
// five squarings and gradient scaling in turn. A finished result waits in the
// output register while the next word is accepted. Configuration writes take
// effect at once; writing beta_start also loads the current beta.
module smooth_heaviside_projection_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [shp_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [shp_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          func,
	input  wire logic [15:0]                   iteration,
	input  wire logic [15:0]                   density_in,
	input  wire logic signed [31:0]            grad_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [15:0]                        density_out,
	output logic signed [31:0]                 grad_out,
	output logic [15:0]                        beta_now
);

	shp_pkg::shp_cmd_t  cmd;
	shp_pkg::shp_stat_t stat;

	shp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	shp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.iteration   (iteration),
		.density_in  (density_in),
		.grad_in     (grad_in),
		.cmd         (cmd),
		.stat        (stat),
		.density_out (density_out),
		.grad_out    (grad_out),
		.beta_now    (beta_now)
	);

`ifndef NO_ASSERTIONS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy)
		else $error("divider still running while accepting words");

	a_density_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> density_out <= 16'h8000)
		else $error("projected density above 1.0");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared without work in flight");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

typedef enum logic {
	WORD_PROJECT = 1'b0,
	WORD_UPDATE  = 1'b1
} word_kind_t;

typedef struct packed {
	logic [15:0] density;
	logic [31:0] grad;
	logic [15:0] beta;
} proj_word_t;

localparam logic [63:0] ONE_Q30   = 64'h4000_0000;
localparam logic [63:0] CLAMP_Q23 = 64'h0800_0000;

class shp_scoreboard;
	logic [15:0] eta;
	logic [15:0] beta_ceiling;
	logic [11:0] factor;
	logic [15:0] period;
	logic [15:0] beta_cur;
	proj_word_t  due[$];
	int          mismatches;

	function new();
		eta          = 16'd16384;
		beta_ceiling = 16'd16384;
		factor       = 12'd512;
		period       = 16'd10;
		beta_cur     = 16'd256;
		mismatches   = 0;
	endfunction

	function void set_reg(logic [shp_pkg::CfgIdxW-1:0] idx, logic [15:0] data);
		case (idx)
			shp_pkg::RegEta:        eta = data;
			shp_pkg::RegBetaStart:  beta_cur = data;
			shp_pkg::RegBetaFinal:  beta_ceiling = data;
			shp_pkg::RegBetaFactor: factor = data[11:0];
			shp_pkg::RegBetaPeriod: period = data;
			default: ;
		endcase
	endfunction

	// Work out the projection or the beta step for one word and queue its result.
	function void note_word(logic fn, logic [15:0] iter, logic [15:0] x, logic [31:0] g);
		proj_word_t  w;
		logic        pos;
		logic [31:0] gmag;
		logic [63:0] ad, u, z, acc, term, den, p, s, q, d, mag, res, cand;
		int          k;
		w = '0;
		if (fn == WORD_UPDATE) begin
			if (iter != 0 && period != 0 && (iter % period) == 0 && beta_cur < beta_ceiling) begin
				cand = (64'(beta_cur) * 64'(factor)) >> 8;
				beta_cur = (cand < 64'(beta_ceiling)) ? cand[15:0] : beta_ceiling;
			end
		end else begin
			pos = (x >= eta);
			ad = pos ? 64'(x) - 64'(eta) : 64'(eta) - 64'(x);
			u = 64'd2 * 64'(beta_cur) * ad;
			if (u > CLAMP_Q23)
				u = CLAMP_Q23;
			// exp(-u/32) by series, then square five times to get exp(-u)
			z = u << 2;
			acc = ONE_Q30;
			term = ONE_Q30;
			for (k = 1; k <= 7; k++) begin
				term = ((term * z) >> 30) / 64'(k);
				if (k % 2 == 1)
					acc = acc - term;
				else
					acc = acc + term;
			end
			for (k = 0; k < 5; k++)
				acc = (acc * acc + (ONE_Q30 >> 1)) >> 30;
			den = ONE_Q30 + acc;
			p = ((64'd1 << 60) + (den >> 1)) / den;
			if (p > ONE_Q30)
				p = ONE_Q30;
			s = pos ? p : ONE_Q30 - p;
			w.density = 16'((s + 64'h4000) >> 15);
			q = (s * (ONE_Q30 - s)) >> 30;
			d = (q * 64'(beta_cur)) >> 13;
			gmag = ~g + 32'd1;
			mag = g[31] ? {32'd0, gmag} : {32'd0, g};
			res = (mag * d + 64'h0080_0000) >> 24;
			if (g[31]) begin
				if (res > 64'h8000_0000)
					res = 64'h8000_0000;
				w.grad = ~res[31:0] + 32'd1;
			end else begin
				if (res > 64'h7FFF_FFFF)
					res = 64'h7FFF_FFFF;
				w.grad = res[31:0];
			end
		end
		w.beta = beta_cur;
		due.push_back(w);
	endfunction

	function void check_result(logic [15:0] dens, logic [31:0] grad, logic [15:0] beta);
		proj_word_t want;
		if (due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result word with none outstanding: density %0d grad %0d beta %0d",
					dens, $signed(grad), beta);
			return;
		end
		want = due.pop_front();
		if (dens !== want.density || grad !== want.grad || beta !== want.beta) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch (exp/got): density %0d/%0d grad %0d/%0d beta %0d/%0d",
					want.density, dens, $signed(want.grad), $signed(grad), want.beta, beta);
		end
	endfunction

	function int pending();
		return due.size();
	endfunction
endclass

module testbench;
	localparam int WATCHDOG = 4000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [shp_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [15:0]                 cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        func = 1'b0;
	logic [15:0]                 iteration = '0;
	logic [15:0]                 density_in = '0;
	logic signed [31:0]          grad_in = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [15:0]                 density_out;
	logic signed [31:0]          grad_out;
	logic [15:0]                 beta_now;

	shp_scoreboard sb;
	int            gap_pct = 0;
	int            stall_pct = 0;
	int            stall_left = 0;
	int            quiet_cycles = 0;
	int            iter_seq = 0;

	smooth_heaviside_projection_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.iteration   (iteration),
		.density_in  (density_in),
		.grad_in     (grad_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.density_out (density_out),
		.grad_out    (grad_out),
		.beta_now    (beta_now)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: stall in bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_index, cfg_data);
			if (out_valid && out_ready)
				sb.check_result(density_out, grad_out, beta_now);
			if (in_valid && in_ready)
				sb.note_word(func, iteration, density_in, grad_in);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	task automatic send_word(input logic fn, input logic [15:0] iter, input logic [15:0] x,
			input logic [31:0] g);
		int gap;
		gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 11) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		iteration <= iter;
		density_in <= x;
		grad_in <= g;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random(input int n);
		int          pick, span, xi;
		logic [15:0] x, iter;
		logic [31:0] g;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				// mostly a running iteration count, as an optimizer would send
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					iter_seq++;
					iter = iter_seq[15:0];
				end else if (pick < 85 && sb.period != 0) begin
					iter = 16'(sb.period * $urandom_range(1, 65535 / sb.period));
				end else begin
					iter = 16'($urandom_range(0, 65535));
				end
				send_word(WORD_UPDATE, iter, 16'($urandom_range(0, 65535)), $urandom);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// stay inside the window where the sigmoid is not flat
					span = (sb.beta_cur == 0) ? 65535 : (1 << 26) / sb.beta_cur + 64;
					if (span > 65535)
						span = 65535;
					xi = int'(sb.eta) + int'($urandom_range(0, 2 * span)) - span;
					if (xi < 0)
						xi = 0;
					if (xi > 65535)
						xi = 65535;
					x = xi[15:0];
				end else if (pick < 80) begin
					x = 16'($urandom_range(0, 32768));
				end else begin
					x = 16'($urandom_range(0, 65535));
				end
				pick = $urandom_range(0, 99);
				if (pick < 70)
					g = $urandom;
				else if (pick < 80)
					g = pick[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
				else
					g = $urandom_range(0, 131071) - 65536;
				send_word(WORD_PROJECT, 16'($urandom_range(0, 65535)), x, g);
			end
		end
	endtask

	// Drop valid and wait for every outstanding result word
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic cfg_word(input logic [shp_pkg::CfgIdxW-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] e, s, c, input logic [11:0] f,
			input logic [15:0] p, input int n, input bit calm);
		drain();
		cfg_word(shp_pkg::RegEta, e);
		cfg_word(shp_pkg::RegBetaStart, s);
		cfg_word(shp_pkg::RegBetaFinal, c);
		cfg_word(shp_pkg::RegBetaFactor, {4'd0, f});
		cfg_word(shp_pkg::RegBetaPeriod, p);
		cfg_we <= 1'b0;
		gap_pct = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
		stall_pct = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
		send_random(n);
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct = 30;
		stall_pct = 30;
		@(posedge clk);

		// Reset settings: density and gradient extremes around eta
		send_word(WORD_PROJECT, 16'd0, 16'd0, 32'h7FFF_FFFF);
		send_word(WORD_PROJECT, 16'hFFFF, 16'd32768, 32'h8000_0000);
		send_word(WORD_PROJECT, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(WORD_PROJECT, 16'd0, 16'd16384, 32'h7FFF_FFFF);
		send_word(WORD_PROJECT, 16'd0, 16'd16383, 32'h0000_0001);
		send_word(WORD_PROJECT, 16'd0, 16'd16385, 32'h8000_0000);
		send_word(WORD_PROJECT, 16'd0, 16'd20000, 32'h1234_5678);
		// Continuation: zero iteration, off-period, on-period, largest iteration
		send_word(WORD_UPDATE, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(WORD_UPDATE, 16'd7, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd10, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd20, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd65535, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd65530, 16'd0, 32'd0);
		send_word(WORD_PROJECT, 16'd0, 16'd16500, 32'h4000_0000);
		// Climb to the ceiling, then one more step that must hold
		send_word(WORD_UPDATE, 16'd30, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd40, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd50, 16'd0, 32'd0);
		send_word(WORD_UPDATE, 16'd60, 16'd0, 32'd0);
		// Steep slope: gradient saturates both ways
		send_word(WORD_PROJECT, 16'd0, 16'd16394, 32'h7FFF_FFFF);
		send_word(WORD_PROJECT, 16'd0, 16'd16380, 32'h8000_0000);

		run_phase(16'd0, 16'd1, 16'd65535, 12'd4095, 16'd1, 120, 1'b0);
		run_phase(16'd32768, 16'd65535, 16'd1, 12'd256, 16'd65535, 80, 1'b0);
		// Zero beta: flat sigmoid, no gradient, no growth
		run_phase(16'd65535, 16'd0, 16'd40000, 12'd700, 16'd5, 60, 1'b0);
		// Zero period: beta never moves
		run_phase(16'd20000, 16'd3000, 16'd50000, 12'd100, 16'd0, 80, 1'b0);
		// Factor below one: beta shrinks toward zero
		run_phase(16'd9000, 16'd60000, 16'd65535, 12'd200, 16'd2, 100, 1'b0);
		run_phase(16'd16384, 16'd128, 16'd16384, 12'd384, 16'd4, 150, 1'b0);
		repeat (2)
			run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
				16'($urandom_range(0, 40)), 120, 1'b0);
		run_phase(16'd16384, 16'd256, 16'd16384, 12'd512, 16'd10, 100, 1'b1);

		drain();
		repeat (80) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
